// ----- rtl/bounded_deque_with_index_read_macros.svh -----
// Assertion macros shared by the deque RTL modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with index read.
// Depends on nothing; used by the interfaces and all deque modules.
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic load;
  } cmd_t;

endpackage

// ----- rtl/bdq_ifs.sv -----
// Request and response channel interfaces of the deque.
// Depends on bdq_pkg for the field widths.
interface bdq_req_if;
  logic                                valid;
  logic                                ready;
  logic [bdq_pkg::OP_W-1:0]            operation;
  logic signed [bdq_pkg::VALUE_W-1:0]  value;
  logic [bdq_pkg::INDEX_W-1:0]         index;

  modport source (output valid, output operation, output value, output index, input ready);
  modport sink (input valid, input operation, input value, input index, output ready);
endinterface

interface bdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bdq_pkg::STATUS_W-1:0]        status;
  logic signed [bdq_pkg::VALUE_W-1:0]  read_value;
  logic [bdq_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink (input valid, input status, input read_value, input count, output ready);
endinterface

// ----- rtl/bdq_ctrl.sv -----
// Sequencing state machine of the deque: request handshake, access, response load.
// Depends on bdq_pkg and the assertion macro header.
`include "bounded_deque_with_index_read_macros.svh"

module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_ready,
  output logic          response_valid,
  input  logic          response_ready,
  output bdq_pkg::cmd_t cmd
);

  bdq_pkg::state_t state;
  bdq_pkg::state_t state_next;
  logic            slot_free;

  assign slot_free = !response_valid || response_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bdq_pkg::ST_IDLE;
      response_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        response_valid <= 1'b1;
      end else if (response_ready) begin
        response_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bdq_pkg::ST_IDLE: begin
        if (request_valid) state_next = bdq_pkg::ST_ACCESS;
      end
      bdq_pkg::ST_ACCESS: begin
        state_next = bdq_pkg::ST_LOAD;
      end
      bdq_pkg::ST_LOAD: begin
        if (slot_free) state_next = bdq_pkg::ST_IDLE;
      end
      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    request_ready = 1'b0;
    cmd           = '0;
    case (state)
      bdq_pkg::ST_IDLE: begin
        request_ready = 1'b1;
        cmd.capture   = request_valid;
      end
      bdq_pkg::ST_ACCESS: begin
        cmd.access = 1'b1;
      end
      bdq_pkg::ST_LOAD: begin
        cmd.load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `BDQ_ASSERT_NEXT(a_capture_then_access, cmd.capture, cmd.access, "capture not followed by access")
  `BDQ_ASSERT_NOW(a_load_needs_slot, cmd.load, slot_free, "response overwritten before taken")
  `BDQ_ASSERT_NOW(a_valid_rise_from_load, $rose(response_valid), $past(cmd.load), "response without load")

endmodule

// ----- rtl/bdq_datapath.sv -----
// Datapath of the deque: request registers, head and count, ring storage, response register.
// Depends on bdq_pkg and the assertion macro header.
`include "bounded_deque_with_index_read_macros.svh"

module bdq_datapath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bdq_pkg::cmd_t                      cmd,
  input  logic [bdq_pkg::OP_W-1:0]           operation,
  input  logic signed [bdq_pkg::VALUE_W-1:0] value,
  input  logic [bdq_pkg::INDEX_W-1:0]        index,
  output logic [bdq_pkg::STATUS_W-1:0]       status,
  output logic signed [bdq_pkg::VALUE_W-1:0] read_value,
  output logic [bdq_pkg::COUNT_W-1:0]        count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > bdq_pkg::INDEX_W) ? CW : bdq_pkg::INDEX_W) + 1;

  logic [bdq_pkg::OP_W-1:0]           op_q;
  logic signed [bdq_pkg::VALUE_W-1:0] value_q;
  logic [bdq_pkg::INDEX_W-1:0]        index_q;

  logic [PW-1:0] head;
  logic [PW-1:0] head_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  logic signed [bdq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [bdq_pkg::VALUE_W-1:0] mem_rd;
  logic [PW-1:0]                      addr;
  logic                               we;

  bdq_pkg::status_t status_next;
  bdq_pkg::status_t status_q;
  logic             read_ok;
  logic             read_ok_q;

  logic          full;
  logic          empty;
  logic          in_range;
  logic [SW-1:0] offset;
  logic [SW-1:0] base;
  logic [SW-1:0] wrapped;
  logic [PW-1:0] head_dec;

  always_comb begin
    full     = fill == CW'(DEPTH);
    empty    = fill == '0;
    in_range = SW'(index_q) < SW'(fill);
    offset   = (op_q == bdq_pkg::OP_READ) ? SW'(index_q) : SW'(fill);
    base     = SW'(head) + offset;
    wrapped  = (base >= SW'(DEPTH)) ? base - SW'(DEPTH) : base;
    head_dec = (head == '0) ? PW'(DEPTH - 1) : head - 1'b1;

    head_next   = head;
    fill_next   = fill;
    status_next = bdq_pkg::STATUS_OK;
    addr        = wrapped[PW-1:0];
    we          = 1'b0;
    read_ok     = 1'b0;

    case (op_q)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = bdq_pkg::STATUS_FULL;
        end else begin
          head_next = head_dec;
          addr      = head_dec;
          we        = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = bdq_pkg::STATUS_FULL;
        end else begin
          we        = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = bdq_pkg::STATUS_EMPTY;
        end else begin
          head_next = (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
          fill_next = fill - 1'b1;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = bdq_pkg::STATUS_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      bdq_pkg::OP_READ: begin
        if (in_range) begin
          read_ok = 1'b1;
        end else begin
          status_next = bdq_pkg::STATUS_RANGE;
        end
      end
      bdq_pkg::OP_CLEAR: begin
        head_next = '0;
        fill_next = '0;
      end
      default: begin
        status_next = bdq_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.access) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      value_q <= value;
      index_q <= index;
    end
    if (cmd.access) begin
      status_q  <= status_next;
      read_ok_q <= read_ok;
    end
    if (cmd.load) begin
      status     <= status_q;
      read_value <= read_ok_q ? mem_rd : '0;
      count      <= bdq_pkg::COUNT_W'(fill);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access && we) begin
      mem[addr] <= value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      mem_rd <= mem[addr];
    end
  end

  `BDQ_ASSERT_NOW(a_fill_bounded, 1'b1, fill <= CW'(DEPTH), "element count beyond depth")
  `BDQ_ASSERT_NOW(a_head_bounded, 1'b1, SW'(head) < SW'(DEPTH), "head pointer beyond depth")
  `BDQ_ASSERT_NEXT(a_push_back_grows, cmd.access && op_q == bdq_pkg::OP_PUSH_BACK && !full,
                   fill == $past(fill) + 1'b1, "push back did not grow the count")

endmodule

// ----- rtl/bounded_deque_with_index_read.sv -----
// Each request passes in order through capture, storage access and response load; the
// load waits until the response slot is free. A new request is accepted only after the
// previous one has been loaded. The single storage port is used in the access step. A
// new request is taken while the previous response still waits. Reset clears head
// pointer, count and handshake state; storage is not cleared and holds no valid bits.
module bounded_deque_with_index_read #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  bdq_req_if.sink     request,
  bdq_rsp_if.source   response
);

  bdq_pkg::cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .request_valid  (request.valid),
    .request_ready  (request.ready),
    .response_valid (response.valid),
    .response_ready (response.ready),
    .cmd            (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (request.operation),
    .value      (request.value),
    .index      (request.index),
    .status     (response.status),
    .read_value (response.read_value),
    .count      (response.count)
  );

endmodule
